// File: hw/rtl/pmcp_pkg.sv
`default_nettype none
package pmcp_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_NAME,
    PH_SKIP,
    PH_DATA,
    PH_CRC,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_XMP  = 3'd1,
    KIND_ICCP = 3'd2,
    KIND_SRGB = 3'd3,
    KIND_CHRM = 3'd4,
    KIND_GAMA = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    STOP_RUN     = 3'd0,
    STOP_SIG     = 3'd1,
    STOP_LEN     = 3'd2,
    STOP_NO_IHDR = 3'd3,
    STOP_CRC     = 3'd4,
    STOP_IEND    = 3'd5
  } stop_t;

  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_ITXT = 32'h6954_5874;
  localparam logic [31:0] TAG_ICCP = 32'h6943_4350;
  localparam logic [31:0] TAG_SRGB = 32'h7352_4742;
  localparam logic [31:0] TAG_CHRM = 32'h6348_524D;
  localparam logic [31:0] TAG_GAMA = 32'h6741_4D41;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

  localparam logic [31:0] IHDR_LEN      = 32'd13;
  localparam logic [31:0] ITXT_MIN_LEN  = 32'd76;
  localparam logic [31:0] SRGB_BODY_LEN = 32'd1;
  localparam logic [31:0] CHRM_BODY_LEN = 32'd32;
  localparam logic [31:0] GAMA_BODY_LEN = 32'd4;
  localparam logic [4:0]  KEYWORD_LEN   = 5'd22;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [2:0] chunk_kind;
    logic       chunk_end;
    logic       chunk_accepted;
    logic       finished;
    logic [2:0] stop_reason;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    case (i)
      3'd0: return 8'h89;
      3'd1: return 8'h50;
      3'd2: return 8'h4E;
      3'd3: return 8'h47;
      3'd4: return 8'h0D;
      3'd5: return 8'h0A;
      3'd6: return 8'h1A;
      default: return 8'h0A;
    endcase
  endfunction

  function automatic logic [7:0] xmp_byte(input logic [4:0] i);
    case (i)
      5'd0:  return 8'h58;
      5'd1:  return 8'h4D;
      5'd2:  return 8'h4C;
      5'd3:  return 8'h3A;
      5'd4:  return 8'h63;
      5'd5:  return 8'h6F;
      5'd6:  return 8'h6D;
      5'd7:  return 8'h2E;
      5'd8:  return 8'h61;
      5'd9:  return 8'h64;
      5'd10: return 8'h6F;
      5'd11: return 8'h62;
      5'd12: return 8'h65;
      5'd13: return 8'h2E;
      5'd14: return 8'h78;
      5'd15: return 8'h6D;
      5'd16: return 8'h70;
      default: return 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pmcp_in_if.sv
`default_nettype none
interface pmcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pmcp_out_if.sv
`default_nettype none
interface pmcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [2:0] chunk_kind;
  logic       chunk_end;
  logic       chunk_accepted;
  logic       finished;
  logic [2:0] stop_reason;

  modport source (output valid, output payload_byte, output payload_valid,
                  output chunk_kind, output chunk_end, output chunk_accepted,
                  output finished, output stop_reason, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input chunk_kind, input chunk_end, input chunk_accepted,
                input finished, input stop_reason, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/png_metadata_chunk_parser.sv
// PNG metadata chunk parser.
// in_ch carries the PNG file, one byte per item; valid/ready handshake.
// out_ch returns exactly one result item per input byte, in order: the
// byte echoed with its kind tag when it is data of a captured chunk,
// chunk_end/chunk_accepted on the byte that settles a captured chunk, and
// finished/stop_reason once the parse has stopped (later bytes are ignored).
// Throughput: one byte per cycle while the output buffer has space. Each byte
// is parsed in the cycle it is accepted (CRC-32 byte step and chunk sequencer
// are combinational); its result is registered into the output buffer.
// The result side holds a two-entry output buffer: while out_ch.ready is
// low, in_ch keeps accepting until both entries are full, then in_ch.ready
// drops until a result is taken. No item is lost or repeated.
// Reset (rst_n low at a clock edge, synchronous) returns the parser to the
// signature check, clears captured-kind history and empties the buffer.
`default_nettype none
module png_metadata_chunk_parser (
  input wire logic    clk,
  input wire logic    rst_n,
  pmcp_in_if.sink     in_ch,
  pmcp_out_if.source  out_ch
);
  import pmcp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] chunk_tag_r, chunk_tag_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] expected_crc_r, expected_crc_nxt;
  logic        header_seen_r, header_seen_nxt;
  logic [4:0]  captured_r, captured_nxt;
  logic        keyword_ok_r, keyword_ok_nxt;
  kind_t       kind_r, kind_nxt;
  stop_t       halt_r, halt_nxt;

  logic  accept;
  logic  buf_space;
  logic  buf_valid;
  res_t  res;
  res_t  head;
  kind_t sel_kind;
  logic  ok_first;

  assign in_ch.ready = buf_space;
  assign accept      = in_ch.valid && buf_space;

  always_comb begin
    logic [7:0] b;
    b = in_ch.data_byte;

    phase_nxt        = phase_r;
    byte_index_nxt   = byte_index_r;
    chunk_length_nxt = chunk_length_r;
    bytes_left_nxt   = bytes_left_r;
    chunk_tag_nxt    = chunk_tag_r;
    crc_nxt          = crc_r;
    expected_crc_nxt = expected_crc_r;
    header_seen_nxt  = header_seen_r;
    captured_nxt     = captured_r;
    keyword_ok_nxt   = keyword_ok_r;
    kind_nxt         = kind_r;
    halt_nxt         = halt_r;
    sel_kind         = KIND_NONE;
    ok_first         = 1'b1;
    res              = '0;

    case (phase_r)
      PH_SIG: begin
        if (b == sig_byte(byte_index_r[2:0])) begin
          byte_index_nxt = byte_index_r + 5'd1;
          if (byte_index_r[2:0] == 3'd7) begin
            byte_index_nxt = 5'd0;
            phase_nxt      = PH_LEN;
          end
        end else begin
          phase_nxt = PH_DONE;
          halt_nxt  = STOP_SIG;
          kind_nxt  = KIND_NONE;
        end
      end
      PH_LEN: begin
        chunk_length_nxt = (byte_index_r == 5'd0) ? {24'd0, b} : {chunk_length_r[23:0], b};
        byte_index_nxt   = byte_index_r + 5'd1;
        if (byte_index_r == 5'd3) begin
          byte_index_nxt = 5'd0;
          if (chunk_length_nxt[31]) begin
            phase_nxt = PH_DONE;
            halt_nxt  = STOP_LEN;
            kind_nxt  = KIND_NONE;
          end else begin
            crc_nxt   = '1;
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        chunk_tag_nxt  = {chunk_tag_r[23:0], b};
        crc_nxt        = crc_byte(crc_r, b);
        byte_index_nxt = byte_index_r + 5'd1;
        if (byte_index_r == 5'd3) begin
          if (!header_seen_r) begin
            if (chunk_length_r == IHDR_LEN && chunk_tag_nxt == TAG_IHDR) begin
              header_seen_nxt = 1'b1;
            end else begin
              ok_first = 1'b0;
            end
          end
          if (chunk_tag_nxt == TAG_ITXT && chunk_length_r > ITXT_MIN_LEN && !captured_r[0]) begin
            sel_kind = KIND_XMP;
          end else if (chunk_tag_nxt == TAG_ICCP && !captured_r[1]) begin
            sel_kind = KIND_ICCP;
          end else if (chunk_tag_nxt == TAG_SRGB && chunk_length_r == SRGB_BODY_LEN
                       && !captured_r[2]) begin
            sel_kind = KIND_SRGB;
          end else if (chunk_tag_nxt == TAG_CHRM && chunk_length_r == CHRM_BODY_LEN
                       && !captured_r[3]) begin
            sel_kind = KIND_CHRM;
          end else if (chunk_tag_nxt == TAG_GAMA && chunk_length_r == GAMA_BODY_LEN
                       && !captured_r[4]) begin
            sel_kind = KIND_GAMA;
          end
          if (!ok_first) begin
            phase_nxt = PH_DONE;
            halt_nxt  = STOP_NO_IHDR;
            kind_nxt  = KIND_NONE;
          end else if (sel_kind == KIND_NONE && chunk_tag_nxt == TAG_IEND) begin
            phase_nxt = PH_DONE;
            halt_nxt  = STOP_IEND;
            kind_nxt  = KIND_NONE;
          end else begin
            byte_index_nxt = 5'd0;
            if (sel_kind == KIND_NONE) begin
              bytes_left_nxt = chunk_length_r + 32'd4;
              phase_nxt      = PH_SKIP;
            end else begin
              kind_nxt       = sel_kind;
              keyword_ok_nxt = 1'b1;
              bytes_left_nxt = chunk_length_r;
              phase_nxt      = (chunk_length_r == 32'd0) ? PH_CRC : PH_DATA;
            end
          end
        end
      end
      PH_SKIP: begin
        bytes_left_nxt = bytes_left_r - 32'd1;
        if (bytes_left_r == 32'd1) begin
          byte_index_nxt = 5'd0;
          phase_nxt      = PH_LEN;
        end
      end
      PH_DATA: begin
        res.payload_byte  = b;
        res.payload_valid = 1'b1;
        res.chunk_kind    = kind_r;
        crc_nxt           = crc_byte(crc_r, b);
        if (kind_r == KIND_XMP && byte_index_r < KEYWORD_LEN) begin
          if (b != xmp_byte(byte_index_r)) begin
            keyword_ok_nxt = 1'b0;
          end
          byte_index_nxt = byte_index_r + 5'd1;
        end
        bytes_left_nxt = bytes_left_r - 32'd1;
        if (bytes_left_r == 32'd1) begin
          byte_index_nxt = 5'd0;
          if (kind_r == KIND_XMP && !keyword_ok_nxt) begin
            res.chunk_end  = 1'b1;
            kind_nxt       = KIND_NONE;
            bytes_left_nxt = 32'd4;
            phase_nxt      = PH_SKIP;
          end else begin
            phase_nxt = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        expected_crc_nxt = (byte_index_r == 5'd0) ? {24'd0, b} : {expected_crc_r[23:0], b};
        byte_index_nxt   = byte_index_r + 5'd1;
        if (byte_index_r == 5'd3) begin
          byte_index_nxt = 5'd0;
          res.chunk_end  = 1'b1;
          res.chunk_kind = kind_r;
          if (expected_crc_nxt == ~crc_r) begin
            res.chunk_accepted = 1'b1;
            case (kind_r)
              KIND_XMP:  captured_nxt = captured_r | 5'b00001;
              KIND_ICCP: captured_nxt = captured_r | 5'b00010;
              KIND_SRGB: captured_nxt = captured_r | 5'b00100;
              KIND_CHRM: captured_nxt = captured_r | 5'b01000;
              KIND_GAMA: captured_nxt = captured_r | 5'b10000;
              default:   captured_nxt = captured_r;
            endcase
            kind_nxt  = KIND_NONE;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_DONE;
            halt_nxt  = STOP_CRC;
            kind_nxt  = KIND_NONE;
          end
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    res.finished    = (phase_nxt == PH_DONE);
    res.stop_reason = (phase_nxt == PH_DONE) ? halt_nxt : STOP_RUN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SIG;
      byte_index_r   <= '0;
      chunk_length_r <= '0;
      bytes_left_r   <= '0;
      chunk_tag_r    <= '0;
      crc_r          <= '1;
      expected_crc_r <= '0;
      header_seen_r  <= 1'b0;
      captured_r     <= '0;
      keyword_ok_r   <= 1'b1;
      kind_r         <= KIND_NONE;
      halt_r         <= STOP_RUN;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      byte_index_r   <= byte_index_nxt;
      chunk_length_r <= chunk_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      chunk_tag_r    <= chunk_tag_nxt;
      crc_r          <= crc_nxt;
      expected_crc_r <= expected_crc_nxt;
      header_seen_r  <= header_seen_nxt;
      captured_r     <= captured_nxt;
      keyword_ok_r   <= keyword_ok_nxt;
      kind_r         <= kind_nxt;
      halt_r         <= halt_nxt;
    end
  end

  pmcp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .space      (buf_space),
    .head_valid (buf_valid),
    .head_data  (head),
    .pop        (out_ch.ready)
  );

  assign out_ch.valid          = buf_valid;
  assign out_ch.payload_byte   = head.payload_byte;
  assign out_ch.payload_valid  = head.payload_valid;
  assign out_ch.chunk_kind     = head.chunk_kind;
  assign out_ch.chunk_end      = head.chunk_end;
  assign out_ch.chunk_accepted = head.chunk_accepted;
  assign out_ch.finished       = head.finished;
  assign out_ch.stop_reason    = head.stop_reason;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("parser left the stopped state");

  a_captured_keep: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (captured_r & $past(captured_r)) == $past(captured_r))
    else $error("captured kind history lost a bit");

  a_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA || phase_r == PH_CRC) |-> kind_r != KIND_NONE)
    else $error("capture phase without a chunk kind");

  a_no_ihdr_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_SIG && phase_r != PH_LEN && phase_r != PH_NAME && phase_r != PH_DONE)
    |-> header_seen_r)
    else $error("chunk body entered before IHDR was seen");

endmodule
`default_nettype wire

// File: hw/rtl/pmcp_out_buf.sv
`default_nettype none
module pmcp_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pmcp_pkg::res_t push_data,
  output logic               space,
  output logic               head_valid,
  output pmcp_pkg::res_t     head_data,
  input  wire logic          pop
);
  import pmcp_pkg::*;

  logic v0_r, v0_nxt, v1_r, v1_nxt;
  res_t s0_r, s0_nxt, s1_r, s1_nxt;

  assign space      = !v1_r;
  assign head_valid = v0_r;
  assign head_data  = s0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (pop && v0_r) begin
      s0_nxt = s1_r;
      v0_nxt = v1_r;
      v1_nxt = 1'b0;
      if (push) begin
        if (v1_r) begin
          s1_nxt = push_data;
          v1_nxt = 1'b1;
        end else begin
          s0_nxt = push_data;
          v0_nxt = 1'b1;
        end
      end
    end else if (push) begin
      if (!v0_r) begin
        s0_nxt = push_data;
        v0_nxt = 1'b1;
      end else begin
        s1_nxt = push_data;
        v1_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

endmodule
`default_nettype wire

// File: test/pmcp_checker.sv
`timescale 1ns / 100ps
module pmcp_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pmcp_in_if          in_ch,
  pmcp_out_if         out_ch,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned payload_cnt,
  output int unsigned settled_cnt,
  output int unsigned accepted_cnt,
  output logic [2:0]  stop_seen
);
  import pmcp_pkg::*;

  localparam logic [63:0]  PNG_SIG       = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [175:0] XMP_KEY       =
    176'h584D4C3A636F6D2E61646F62652E786D70_0000000000;
  localparam logic [31:0]  MAX_CHUNK_LEN = 32'h7FFF_FFFF;

  phase_t      ph;
  logic [4:0]  idx;
  logic [31:0] clen;
  logic [31:0] left;
  logic [31:0] tag;
  logic [31:0] crc;
  logic [31:0] file_crc;
  logic        hdr_seen;
  logic        kw_ok;
  logic [5:1]  taken;
  kind_t       cur;
  stop_t       why;
  res_t        due_results[$];

  function automatic logic [31:0] crc_shift(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ b[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic string fmt(input res_t r);
    return $sformatf("byte %02h/%0b kind %0d end %0b acc %0b fin %0b stop %0d",
                     r.payload_byte, r.payload_valid, r.chunk_kind, r.chunk_end,
                     r.chunk_accepted, r.finished, r.stop_reason);
  endfunction

  task automatic stop_parse(input stop_t code);
    ph  = PH_DONE;
    why = code;
    cur = KIND_NONE;
  endtask

  task automatic open_chunk();
    kind_t k;
    k = KIND_NONE;
    if (!hdr_seen) begin
      if (clen == IHDR_LEN && tag == TAG_IHDR) begin
        hdr_seen = 1'b1;
      end else begin
        stop_parse(STOP_NO_IHDR);
        return;
      end
    end
    if (tag == TAG_ITXT && clen > ITXT_MIN_LEN && !taken[KIND_XMP]) begin
      k = KIND_XMP;
    end else if (tag == TAG_ICCP && !taken[KIND_ICCP]) begin
      k = KIND_ICCP;
    end else if (tag == TAG_SRGB && clen == SRGB_BODY_LEN && !taken[KIND_SRGB]) begin
      k = KIND_SRGB;
    end else if (tag == TAG_CHRM && clen == CHRM_BODY_LEN && !taken[KIND_CHRM]) begin
      k = KIND_CHRM;
    end else if (tag == TAG_GAMA && clen == GAMA_BODY_LEN && !taken[KIND_GAMA]) begin
      k = KIND_GAMA;
    end else if (tag == TAG_IEND) begin
      stop_parse(STOP_IEND);
      return;
    end
    idx = '0;
    if (k == KIND_NONE) begin
      left = clen + 32'd4;
      ph   = PH_SKIP;
    end else begin
      cur   = k;
      kw_ok = 1'b1;
      left  = clen;
      ph    = (clen == 0) ? PH_CRC : PH_DATA;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, output res_t r);
    r = '0;
    case (ph)
      PH_SIG: begin
        if (idx < 8 && b == PNG_SIG[8 * (7 - idx) +: 8]) begin
          idx = idx + 5'd1;
          if (idx == 8) begin
            idx = '0;
            ph  = PH_LEN;
          end
        end else begin
          stop_parse(STOP_SIG);
        end
      end
      PH_LEN: begin
        clen = (idx == 0) ? {24'd0, b} : {clen[23:0], b};
        idx  = idx + 5'd1;
        if (idx >= 4) begin
          idx = '0;
          if (clen > MAX_CHUNK_LEN) begin
            stop_parse(STOP_LEN);
          end else begin
            crc = '1;
            ph  = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        tag = {tag[23:0], b};
        crc = crc_shift(crc, b);
        idx = idx + 5'd1;
        if (idx >= 4) open_chunk();
      end
      PH_SKIP: begin
        left = left - 32'd1;
        if (left == 0) begin
          idx = '0;
          ph  = PH_LEN;
        end
      end
      PH_DATA: begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        r.chunk_kind    = cur;
        crc = crc_shift(crc, b);
        if (cur == KIND_XMP && idx < KEYWORD_LEN) begin
          if (b != XMP_KEY[8 * (21 - idx) +: 8]) kw_ok = 1'b0;
          idx = idx + 5'd1;
        end
        left = left - 32'd1;
        if (left == 0) begin
          idx = '0;
          if (cur == KIND_XMP && !kw_ok) begin
            r.chunk_end = 1'b1;
            cur  = KIND_NONE;
            left = 32'd4;
            ph   = PH_SKIP;
          end else begin
            ph = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        file_crc = (idx == 0) ? {24'd0, b} : {file_crc[23:0], b};
        idx = idx + 5'd1;
        if (idx >= 4) begin
          idx          = '0;
          r.chunk_end  = 1'b1;
          r.chunk_kind = cur;
          if (file_crc == ~crc) begin
            r.chunk_accepted = 1'b1;
            if (cur != KIND_NONE) taken[cur] = 1'b1;
            cur = KIND_NONE;
            ph  = PH_LEN;
          end else begin
            stop_parse(STOP_CRC);
          end
        end
      end
      default: ;
    endcase
    r.finished    = (ph == PH_DONE);
    r.stop_reason = (ph == PH_DONE) ? why : STOP_RUN;
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (!rst_n) begin
      ph       = PH_SIG;
      idx      = '0;
      clen     = '0;
      left     = '0;
      tag      = '0;
      crc      = '1;
      file_crc = '0;
      hdr_seen = 1'b0;
      taken    = '0;
      kw_ok    = 1'b1;
      cur      = KIND_NONE;
      why      = STOP_RUN;
      due_results.delete();
      errors       = 0;
      payload_cnt  = 0;
      settled_cnt  = 0;
      accepted_cnt = 0;
      stop_seen    = STOP_RUN;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data_byte, want);
        due_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.payload_byte   = out_ch.payload_byte;
        got.payload_valid  = out_ch.payload_valid;
        got.chunk_kind     = out_ch.chunk_kind;
        got.chunk_end      = out_ch.chunk_end;
        got.chunk_accepted = out_ch.chunk_accepted;
        got.finished       = out_ch.finished;
        got.stop_reason    = out_ch.stop_reason;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with no byte pending: %s", $time, fmt(got));
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch, expected %s", $time, fmt(want));
            $display("%0t:                  actual   %s", $time, fmt(got));
          end
          payload_cnt  += got.payload_valid;
          settled_cnt  += got.chunk_end;
          accepted_cnt += got.chunk_accepted;
          stop_seen     = got.stop_reason;
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import pmcp_pkg::*;

  localparam int ITEMS      = 1750;
  localparam int PHASE_LEN  = 600;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 10;
  localparam int TAIL       = 30;

  localparam logic [63:0]  PNG_SIG  = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [175:0] XMP_KEY  =
    176'h584D4C3A636F6D2E61646F62652E786D70_0000000000;
  localparam logic [31:0]  TAG_TEXT = 32'h7445_5874;

  logic        clk;
  logic        rst_n;
  int          gap_pct;
  int          stall_pct;
  int          bytes_sent;
  int          idle_cycles = 0;
  logic [5:1]  kinds_done;
  logic [7:0]  body[$];
  int unsigned errors;
  int unsigned pending;
  int unsigned payload_cnt;
  int unsigned settled_cnt;
  int unsigned accepted_cnt;
  logic [2:0]  stop_seen;

  pmcp_in_if  in_ch ();
  pmcp_out_if out_ch ();

  png_metadata_chunk_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pmcp_checker i_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .errors       (errors),
    .pending      (pending),
    .payload_cnt  (payload_cnt),
    .settled_cnt  (settled_cnt),
    .accepted_cnt (accepted_cnt),
    .stop_seen    (stop_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    if (bytes_sent == PHASE_LEN) begin
      gap_pct   = 72;
      stall_pct = 23;
    end else if (bytes_sent == 2 * PHASE_LEN) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic fill_body(input int n);
    body.delete();
    repeat (n) body.push_back(8'($urandom_range(0, 255)));
  endtask

  // stamp the keyword; flip >= 0 spoils one of its bytes
  task automatic put_keyword(input int flip);
    for (int i = 0; i < KEYWORD_LEN; i++) body[i] = XMP_KEY[8 * (21 - i) +: 8];
    if (flip >= 0) body[flip] = body[flip] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic send_chunk(input logic [31:0] tag, input bit bad_crc);
    logic [31:0] len;
    logic [31:0] c;
    bit          kw_good;
    len     = body.size();
    kw_good = (len >= KEYWORD_LEN);
    for (int i = 0; i < KEYWORD_LEN && i < len; i++) begin
      if (body[i] != XMP_KEY[8 * (21 - i) +: 8]) kw_good = 0;
    end
    for (int i = 3; i >= 0; i--) put_byte(len[8 * i +: 8]);
    c = '1;
    for (int i = 3; i >= 0; i--) begin
      put_byte(tag[8 * i +: 8]);
      c = crc_next(c, tag[8 * i +: 8]);
    end
    foreach (body[i]) begin
      put_byte(body[i]);
      c = crc_next(c, body[i]);
    end
    c = ~c;
    if (bad_crc) c = c ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 3; i >= 0; i--) put_byte(c[8 * i +: 8]);
    if (!bad_crc) begin
      if (tag == TAG_ITXT && len > ITXT_MIN_LEN && kw_good) kinds_done[KIND_XMP] = 1'b1;
      else if (tag == TAG_ICCP) kinds_done[KIND_ICCP] = 1'b1;
      else if (tag == TAG_SRGB && len == SRGB_BODY_LEN) kinds_done[KIND_SRGB] = 1'b1;
      else if (tag == TAG_CHRM && len == CHRM_BODY_LEN) kinds_done[KIND_CHRM] = 1'b1;
      else if (tag == TAG_GAMA && len == GAMA_BODY_LEN) kinds_done[KIND_GAMA] = 1'b1;
    end
  endtask

  task automatic send_directed();
    fill_body(IHDR_LEN);
    body[0]  = 8'h00;
    body[12] = 8'hFF;
    send_chunk(TAG_IHDR, 1'b0);
    // keyword wrong only in its last pad byte: dropped, CRC unchecked
    fill_body(77);
    put_keyword(21);
    send_chunk(TAG_ITXT, 1'b0);
    body.delete();
    send_chunk(TAG_ICCP, 1'b0);
    body.delete();
    body.push_back(8'hFF);
    send_chunk(TAG_SRGB, 1'b0);
    body[0] = 8'h00;
    send_chunk(TAG_SRGB, 1'b0);
    fill_body(3);
    send_chunk(TAG_GAMA, 1'b0);
    body.delete();
    send_chunk(TAG_TEXT, 1'b0);
  endtask

  task automatic send_random_chunk();
    int          pick;
    logic [31:0] tag;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      tag = TAG_ITXT;
      if ($urandom_range(0, 9) == 0) begin
        fill_body($urandom_range(0, 76));
      end else begin
        fill_body($urandom_range(77, 110));
        if ($urandom_range(0, 19) != 0) begin
          put_keyword(($urandom_range(0, 19) != 0) ? $urandom_range(0, 21) : -1);
        end
      end
    end else if (pick < 42) begin
      tag = TAG_ICCP;
      fill_body($urandom_range(0, 24));
    end else if (pick < 52) begin
      tag = TAG_SRGB;
      fill_body(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 3));
    end else if (pick < 62) begin
      tag = TAG_CHRM;
      fill_body(($urandom_range(0, 3) == 0) ? 32 : $urandom_range(28, 36));
    end else if (pick < 72) begin
      tag = TAG_GAMA;
      fill_body(($urandom_range(0, 3) == 0) ? 4 : $urandom_range(0, 8));
    end else if (pick < 78) begin
      tag = TAG_IHDR;
      fill_body(IHDR_LEN);
    end else begin
      do tag = $urandom; while (tag == TAG_IEND);
      fill_body($urandom_range(0, 40));
    end
    send_chunk(tag, 1'b0);
  endtask

  task automatic end_parse();
    logic [31:0] len;
    case ($urandom_range(0, 2))
      0: begin
        len     = $urandom;
        len[31] = 1'b1;
        if ($urandom_range(0, 1) == 0) len = 32'h8000_0000;
        for (int i = 3; i >= 0; i--) put_byte(len[8 * i +: 8]);
      end
      1: begin
        if (!kinds_done[KIND_GAMA]) begin
          fill_body(GAMA_BODY_LEN);
          send_chunk(TAG_GAMA, 1'b1);
        end else if (!kinds_done[KIND_CHRM]) begin
          fill_body(CHRM_BODY_LEN);
          send_chunk(TAG_CHRM, 1'b1);
        end else if (!kinds_done[KIND_XMP]) begin
          fill_body($urandom_range(77, 90));
          put_keyword(-1);
          send_chunk(TAG_ITXT, 1'b1);
        end else if (!kinds_done[KIND_SRGB]) begin
          fill_body(SRGB_BODY_LEN);
          send_chunk(TAG_SRGB, 1'b1);
        end else begin
          body.delete();
          send_chunk(TAG_IEND, 1'b0);
        end
      end
      default: begin
        body.delete();
        send_chunk(TAG_IEND, 1'b0);
      end
    endcase
  endtask

  initial begin : stimulus
    int mode;
    int k;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    rst_n           = 1'b0;
    gap_pct         = 23;
    stall_pct       = 72;
    bytes_sent      = 0;
    kinds_done      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    mode = $urandom_range(0, 15);
    if (mode == 0) begin
      k = $urandom_range(0, 7);
      for (int i = 0; i < k; i++) put_byte(PNG_SIG[8 * (7 - i) +: 8]);
      put_byte(PNG_SIG[8 * (7 - k) +: 8] ^ 8'($urandom_range(1, 255)));
    end else begin
      for (int i = 0; i < 8; i++) put_byte(PNG_SIG[8 * (7 - i) +: 8]);
      if (mode == 1) begin
        case ($urandom_range(0, 2))
          0: begin
            fill_body(($urandom_range(0, 1) == 0) ? $urandom_range(0, 12)
                                                  : $urandom_range(14, 20));
            send_chunk(TAG_IHDR, 1'b0);
          end
          1: begin
            fill_body(IHDR_LEN);
            send_chunk(TAG_SRGB, 1'b0);
          end
          default: begin
            body.delete();
            send_chunk(TAG_IEND, 1'b0);
          end
        endcase
      end else begin
        send_directed();
        while (bytes_sent < ITEMS) send_random_chunk();
        end_parse();
      end
    end
    // stopped parser: these bytes must be ignored
    repeat (TAIL) put_byte(8'($urandom_range(0, 255)));
    while (bytes_sent < ITEMS) put_byte(8'($urandom_range(0, 255)));
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("Streamed %0d bytes: %0d captured data bytes, %0d chunk verdicts, %0d accepted.",
             bytes_sent, payload_cnt, settled_cnt, accepted_cnt);
    $display("Parse ended with stop reason %0d (start mode %0d).", stop_seen, mode);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
